[sv/lprf_pkg.sv]
// Shared types and constants of the length-prefixed record queue.
// Holds the command and result item formats and the engine state encoding.
// No dependencies.
package lprf_pkg;

    localparam int BYTE_W     = 8;
    localparam int LEN_W      = 6;
    localparam int USED_W     = 10;
    localparam int DROP_W     = 9;
    localparam int HDR_BYTES  = 2;
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);
    localparam int RESQ_DEPTH = 4;
    localparam int RESQ_AW    = $clog2(RESQ_DEPTH);
    localparam int RESQ_CW    = $clog2(RESQ_DEPTH + 1);

    typedef enum logic [1:0] {
        OP_PUSH_HDR  = 2'd0,
        OP_PUSH_DATA = 2'd1,
        OP_POP       = 2'd2,
        OP_CLEAR     = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_FULL    = 3'd1,
        ST_EMPTY   = 3'd2,
        ST_CORRUPT = 3'd3,
        ST_STRAY   = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HDR_CHK,
        S_HDR_HI,
        S_DROP_LO,
        S_DROP_HI,
        S_POP_LO,
        S_POP_HI,
        S_POP_DATA
    } state_t;

    typedef struct packed {
        op_t               op;
        logic [BYTE_W-1:0] data_byte;
        logic [LEN_W-1:0]  record_length;
    } cmd_t;

    typedef struct packed {
        status_t           status;
        logic [BYTE_W-1:0] out_byte;
        logic              byte_valid;
        logic [LEN_W-1:0]  popped_length;
        logic              last;
        logic [USED_W-1:0] used_bytes;
        logic [DROP_W-1:0] dropped_records;
    } res_t;

endpackage

[sv/lprf_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Read data holds its value while no read is issued.
// No dependencies.
module lprf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[sv/lprf_front.sv]
// Front end: accepts input items, classifies the operation code and
// queues the commands for the engine. Depends on lprf_pkg.
module lprf_front
    import lprf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [1:0]        operation,
    input  logic [BYTE_W-1:0] data_byte,
    input  logic [LEN_W-1:0]  record_length,
    output logic              cmd_valid,
    output cmd_t              cmd,
    input  logic              cmd_done
);

    cmd_t               q_reg [CMDQ_DEPTH];
    logic [CMDQ_AW-1:0] wr_reg, wr_next;
    logic [CMDQ_AW-1:0] rd_reg, rd_next;
    logic [CMDQ_CW-1:0] count_reg, count_next;
    logic               accept;
    cmd_t               incoming;

    assign full   = (count_reg == CMDQ_CW'(CMDQ_DEPTH));
    assign accept = push && !full;

    always_comb
    begin
        incoming.op            = op_t'(operation);
        incoming.data_byte     = data_byte;
        incoming.record_length = record_length;
    end

    always_comb
    begin
        wr_next    = accept ? wr_reg + 1'b1 : wr_reg;
        rd_next    = cmd_done ? rd_reg + 1'b1 : rd_reg;
        count_next = count_reg + CMDQ_CW'(accept) - CMDQ_CW'(cmd_done);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            q_reg[wr_reg] <= incoming;
        end
    end

    assign cmd_valid = (count_reg != '0);
    assign cmd       = q_reg[rd_reg];

endmodule

[sv/lprf_resq.sv]
// Result queue between the engine and the output port.
// Small register queue; the engine reserves room before it emits an item.
// Depends on lprf_pkg.
module lprf_resq
    import lprf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  res_t               push_data,
    input  logic               pop,
    output res_t               head,
    output logic               empty,
    output logic [RESQ_CW-1:0] count
);

    res_t               q_reg [RESQ_DEPTH];
    logic [RESQ_AW-1:0] wr_reg, wr_next;
    logic [RESQ_AW-1:0] rd_reg, rd_next;
    logic [RESQ_CW-1:0] count_reg, count_next;
    logic               take;

    assign empty = (count_reg == '0);
    assign take  = pop && !empty;

    always_comb
    begin
        wr_next    = push ? wr_reg + 1'b1 : wr_reg;
        rd_next    = take ? rd_reg + 1'b1 : rd_reg;
        count_next = count_reg + RESQ_CW'(push) - RESQ_CW'(take);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_reg] <= push_data;
        end
    end

    assign head  = q_reg[rd_reg];
    assign count = count_reg;

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && (count_reg == RESQ_CW'(RESQ_DEPTH))))
        else $error("result queue written while full");
`endif

endmodule

[sv/lprf_back.sv]
// Back end: the record engine. Owns the ring pointers, the byte store and
// the sequencer that writes headers and data bytes, drops and pops records
// and clears the ring. Depends on lprf_pkg and lprf_ram.
module lprf_back
    import lprf_pkg::*;
#(
    parameter int DEPTH      = 1024,
    parameter int MAX_RECORD = 63
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write_en,
    input  logic               cfg_write_data,
    input  logic               cmd_valid,
    input  cmd_t               cmd,
    output logic               cmd_done,
    input  logic [RESQ_CW-1:0] resq_count,
    output logic               res_valid,
    output res_t               res
);

    localparam int AW = $clog2(DEPTH);
    localparam int SW = ((AW > 9) ? AW : 9) + 1;
    localparam logic [AW-1:0] LAST_POS = AW'(DEPTH - 1);
    localparam logic [SW-1:0] DEPTH_S  = SW'(DEPTH);
    localparam logic [AW:0]   DEPTH_U  = (AW + 1)'(DEPTH);

    function automatic logic [AW-1:0] next_pos(input logic [AW-1:0] p);
        return (p == LAST_POS) ? '0 : p + 1'b1;
    endfunction

    // Position just past a record of n data bytes starting at p.
    function automatic logic [AW-1:0] skip_rec(input logic [AW-1:0] p,
                                               input logic [BYTE_W-1:0] n);
        logic [SW-1:0] s;
        s = SW'(p) + SW'(HDR_BYTES) + SW'(n);
        if (s >= DEPTH_S)
        begin
            s = s - DEPTH_S;
        end
        return s[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] used_of(input logic [AW-1:0] c,
                                              input logic [AW-1:0] r);
        logic [AW:0] d;
        d = {1'b0, c} - {1'b0, r};
        if (d[AW])
        begin
            d = d + DEPTH_U;
        end
        return d[AW-1:0];
    endfunction

    state_t            state_reg, state_next;
    logic [AW-1:0]     rp_reg, rp_next;
    logic [AW-1:0]     cp_reg, cp_next;
    logic [AW-1:0]     wp_reg, wp_next;
    logic [AW-1:0]     dptr_reg, dptr_next;
    logic [LEN_W-1:0]  expect_reg, expect_next;
    logic [LEN_W-1:0]  remain_reg, remain_next;
    logic [LEN_W-1:0]  plen_reg, plen_next;
    logic [BYTE_W-1:0] lo_reg, lo_next;
    logic [DROP_W-1:0] drop_reg, drop_next;
    logic              open_reg, open_next;
    logic              pending_reg, pending_next;
    logic              plast_reg, plast_next;
    logic              replace_reg;

    logic              mem_we, mem_re;
    logic [AW-1:0]     mem_waddr, mem_raddr;
    logic [BYTE_W-1:0] mem_wdata, mem_rdata;

    logic [AW-1:0]     used_cur;
    logic              can_emit, go, fits, corrupt, q_empty, len_bad;

    lprf_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign used_cur = used_of(cp_reg, rp_reg);
    assign q_empty  = (rp_reg == cp_reg);
    assign len_bad  = (cmd.record_length > LEN_W'(MAX_RECORD));
    // Room in the result queue, counting a store read still in flight.
    assign can_emit = ((RESQ_CW + 1)'(resq_count) + (RESQ_CW + 1)'(pending_reg))
                      < (RESQ_CW + 1)'(RESQ_DEPTH);
    assign go       = cmd_valid && !pending_reg && can_emit;
    // Free space strictly greater than length plus header.
    assign fits     = (SW'(used_cur) + SW'(cmd.record_length) + SW'(HDR_BYTES + 1))
                      < DEPTH_S;
    // Evaluated when the header's high byte sits on the store read port.
    assign corrupt  = (mem_rdata != '0) || (lo_reg > BYTE_W'(MAX_RECORD)) ||
                      (SW'(used_cur) < (SW'(lo_reg) + SW'(HDR_BYTES)));

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (go)
                begin
                    unique case (cmd.op)
                        OP_PUSH_HDR:  state_next = len_bad ? S_IDLE : S_HDR_CHK;
                        OP_POP:       state_next = q_empty ? S_IDLE : S_POP_LO;
                        OP_PUSH_DATA: state_next = S_IDLE;
                        OP_CLEAR:     state_next = S_IDLE;
                        default:      state_next = S_IDLE;
                    endcase
                end
            end
            S_HDR_CHK:
            begin
                if (fits)
                begin
                    state_next = S_HDR_HI;
                end
                else if (replace_reg && !q_empty)
                begin
                    state_next = S_DROP_LO;
                end
                else if (can_emit)
                begin
                    state_next = S_IDLE;
                end
            end
            S_HDR_HI:   state_next = can_emit ? S_IDLE : S_HDR_HI;
            S_DROP_LO:  state_next = S_DROP_HI;
            S_DROP_HI:  state_next = S_HDR_CHK;
            S_POP_LO:   state_next = S_POP_HI;
            S_POP_HI:
            begin
                if (can_emit)
                begin
                    state_next = (corrupt || (lo_reg == '0)) ? S_IDLE : S_POP_DATA;
                end
            end
            S_POP_DATA:
            begin
                if (can_emit && (remain_reg == LEN_W'(1)))
                begin
                    state_next = S_IDLE;
                end
            end
            default:    state_next = S_IDLE;
        endcase
    end

    // Datapath, store access and result emission.
    always_comb
    begin
        rp_next      = rp_reg;
        cp_next      = cp_reg;
        wp_next      = wp_reg;
        dptr_next    = dptr_reg;
        expect_next  = expect_reg;
        remain_next  = remain_reg;
        plen_next    = plen_reg;
        lo_next      = lo_reg;
        drop_next    = drop_reg;
        open_next    = open_reg;
        pending_next = 1'b0;
        plast_next   = plast_reg;
        mem_we       = 1'b0;
        mem_waddr    = wp_reg;
        mem_wdata    = cmd.data_byte;
        mem_re       = 1'b0;
        mem_raddr    = rp_reg;
        cmd_done     = 1'b0;
        res_valid    = 1'b0;
        res          = '0;
        res.status   = ST_OK;

        // Data byte read in the previous cycle.
        if (pending_reg)
        begin
            res_valid         = 1'b1;
            res.out_byte      = mem_rdata;
            res.byte_valid    = 1'b1;
            res.popped_length = plen_reg;
            res.last          = plast_reg;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (go)
                begin
                    unique case (cmd.op)
                        OP_PUSH_HDR:
                        begin
                            wp_next     = cp_reg;
                            open_next   = 1'b0;
                            expect_next = '0;
                            drop_next   = '0;
                            if (len_bad)
                            begin
                                res_valid  = 1'b1;
                                res.status = ST_FULL;
                                res.last   = 1'b1;
                                cmd_done   = 1'b1;
                            end
                        end
                        OP_PUSH_DATA:
                        begin
                            res_valid = 1'b1;
                            res.last  = 1'b1;
                            cmd_done  = 1'b1;
                            if (open_reg)
                            begin
                                mem_we      = 1'b1;
                                wp_next     = next_pos(wp_reg);
                                expect_next = expect_reg - 1'b1;
                                if (expect_reg == LEN_W'(1))
                                begin
                                    cp_next   = next_pos(wp_reg);
                                    open_next = 1'b0;
                                end
                            end
                            else
                            begin
                                res.status = ST_STRAY;
                            end
                        end
                        OP_POP:
                        begin
                            if (q_empty)
                            begin
                                res_valid  = 1'b1;
                                res.status = ST_EMPTY;
                                res.last   = 1'b1;
                                cmd_done   = 1'b1;
                            end
                            else
                            begin
                                mem_re = 1'b1;
                            end
                        end
                        OP_CLEAR:
                        begin
                            rp_next     = '0;
                            cp_next     = '0;
                            wp_next     = '0;
                            open_next   = 1'b0;
                            expect_next = '0;
                            res_valid   = 1'b1;
                            res.last    = 1'b1;
                            cmd_done    = 1'b1;
                        end
                        default:
                        begin
                            cmd_done = 1'b0;
                        end
                    endcase
                end
            end
            S_HDR_CHK:
            begin
                if (fits)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = cp_reg;
                    mem_wdata = BYTE_W'(cmd.record_length);
                end
                else if (replace_reg && !q_empty)
                begin
                    mem_re = 1'b1;
                end
                else if (can_emit)
                begin
                    res_valid           = 1'b1;
                    res.status          = ST_FULL;
                    res.last            = 1'b1;
                    res.dropped_records = drop_reg;
                    cmd_done            = 1'b1;
                end
            end
            S_HDR_HI:
            begin
                if (can_emit)
                begin
                    mem_we              = 1'b1;
                    mem_waddr           = next_pos(cp_reg);
                    mem_wdata           = '0;
                    res_valid           = 1'b1;
                    res.last            = 1'b1;
                    res.dropped_records = drop_reg;
                    cmd_done            = 1'b1;
                    if (cmd.record_length == '0)
                    begin
                        cp_next = skip_rec(cp_reg, '0);
                        wp_next = skip_rec(cp_reg, '0);
                    end
                    else
                    begin
                        wp_next     = skip_rec(cp_reg, '0);
                        open_next   = 1'b1;
                        expect_next = cmd.record_length;
                    end
                end
            end
            S_DROP_LO, S_POP_LO:
            begin
                lo_next   = mem_rdata;
                mem_re    = 1'b1;
                mem_raddr = next_pos(rp_reg);
            end
            S_DROP_HI:
            begin
                if (corrupt)
                begin
                    rp_next     = '0;
                    cp_next     = '0;
                    wp_next     = '0;
                    open_next   = 1'b0;
                    expect_next = '0;
                end
                else
                begin
                    rp_next   = skip_rec(rp_reg, lo_reg);
                    drop_next = drop_reg + 1'b1;
                end
            end
            S_POP_HI:
            begin
                if (can_emit)
                begin
                    if (corrupt)
                    begin
                        rp_next     = '0;
                        cp_next     = '0;
                        wp_next     = '0;
                        open_next   = 1'b0;
                        expect_next = '0;
                        res_valid   = 1'b1;
                        res.status  = ST_CORRUPT;
                        res.last    = 1'b1;
                        cmd_done    = 1'b1;
                    end
                    else
                    begin
                        rp_next = skip_rec(rp_reg, lo_reg);
                        if (lo_reg == '0)
                        begin
                            res_valid = 1'b1;
                            res.last  = 1'b1;
                            cmd_done  = 1'b1;
                        end
                        else
                        begin
                            dptr_next   = skip_rec(rp_reg, '0);
                            remain_next = lo_reg[LEN_W-1:0];
                            plen_next   = lo_reg[LEN_W-1:0];
                        end
                    end
                end
            end
            S_POP_DATA:
            begin
                if (can_emit)
                begin
                    mem_re       = 1'b1;
                    mem_raddr    = dptr_reg;
                    dptr_next    = next_pos(dptr_reg);
                    remain_next  = remain_reg - 1'b1;
                    pending_next = 1'b1;
                    plast_next   = (remain_reg == LEN_W'(1));
                    cmd_done     = (remain_reg == LEN_W'(1));
                end
            end
            default:
            begin
                cmd_done = 1'b0;
            end
        endcase

        res.used_bytes = USED_W'(used_of(cp_next, rp_next));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            rp_reg      <= '0;
            cp_reg      <= '0;
            wp_reg      <= '0;
            expect_reg  <= '0;
            open_reg    <= 1'b0;
            pending_reg <= 1'b0;
            replace_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rp_reg      <= rp_next;
            cp_reg      <= cp_next;
            wp_reg      <= wp_next;
            expect_reg  <= expect_next;
            open_reg    <= open_next;
            pending_reg <= pending_next;
            if (cfg_write_en)
            begin
                replace_reg <= cfg_write_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        dptr_reg   <= dptr_next;
        remain_reg <= remain_next;
        plen_reg   <= plen_next;
        lo_reg     <= lo_next;
        drop_reg   <= drop_next;
        plast_reg  <= plast_next;
    end

`ifndef SYNTHESIS
    a_open_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        open_reg |-> (expect_reg != '0))
        else $error("record open with no bytes outstanding");

    a_closed_wp: assert property (@(posedge clk) disable iff (!rst_n)
        !open_reg |-> (wp_reg == cp_reg))
        else $error("write pointer left ahead of commit pointer");

    a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_done |=> (state_reg == S_IDLE))
        else $error("engine busy after finishing an item");
`endif

endmodule

[sv/length_prefixed_record_fifo.sv]
// Top level of the length-prefixed record queue.
// Depends on lprf_pkg, lprf_front, lprf_back, lprf_resq and lprf_ram.
//
// Usage. Input items enter through a queue-like port: an item is taken on a
// rising edge with push high and full low. Each item is a push header, a
// push data byte, a pop or a clear. Result items leave through a second
// queue-like port: the oldest result sits on the result ports while empty is
// low and is taken on an edge with pop high. A pop of a record of L bytes
// (L > 0) yields L result items, each with its data byte; others yield
// exactly one. The user writes replace_mode via cfg_write_en/cfg_write_data
// only while the block is idle; the block itself does not enforce this.
//
// Timing. A two-entry command queue feeds the record engine, which works on
// one item at a time. Push data byte, clear, a stray byte and a pop of an
// empty queue finish in the idle state; a push header writes its length byte
// in the fit check and then its high byte (a header turned away stops at the
// check), with a read of both header bytes per record dropped in replace
// mode; a pop reads and checks the header, then reads one data byte per
// cycle while the result queue has room, set by the single read port of the
// byte store; the next item waits until the last byte's read has landed.
//
// Reset clears the pointers, the open record and replace_mode; the byte
// store needs no clearing. When the receiver stalls, the four-entry result
// queue fills, the engine waits and the command queue then raises full.
module length_prefixed_record_fifo
    import lprf_pkg::*;
#(
    parameter int DEPTH      = 1024,
    parameter int MAX_RECORD = 63
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write_en,
    input  logic              cfg_write_data,
    input  logic              push,
    output logic              full,
    input  logic [1:0]        operation,
    input  logic [BYTE_W-1:0] data_byte,
    input  logic [LEN_W-1:0]  record_length,
    output logic              empty,
    input  logic              pop,
    output logic [2:0]        status,
    output logic [BYTE_W-1:0] out_byte,
    output logic              byte_valid,
    output logic [LEN_W-1:0]  popped_length,
    output logic              last,
    output logic [USED_W-1:0] used_bytes,
    output logic [DROP_W-1:0] dropped_records
);

    // Command path from the front end to the engine.
    logic cmd_valid;
    cmd_t cmd;
    logic cmd_done;

    // Result path from the engine to the output queue; the engine watches
    // the fill level so that a store read never lands on a full queue.
    logic               res_valid;
    res_t               res;
    res_t               head;
    logic [RESQ_CW-1:0] resq_count;

    lprf_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .operation     (operation),
        .data_byte     (data_byte),
        .record_length (record_length),
        .cmd_valid     (cmd_valid),
        .cmd           (cmd),
        .cmd_done      (cmd_done)
    );

    lprf_back #(
        .DEPTH      (DEPTH),
        .MAX_RECORD (MAX_RECORD)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .cmd_valid      (cmd_valid),
        .cmd            (cmd),
        .cmd_done       (cmd_done),
        .resq_count     (resq_count),
        .res_valid      (res_valid),
        .res            (res)
    );

    lprf_resq u_resq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .pop       (pop),
        .head      (head),
        .empty     (empty),
        .count     (resq_count)
    );

    // The oldest waiting result item drives the result ports.
    assign status          = head.status;
    assign out_byte        = head.out_byte;
    assign byte_valid      = head.byte_valid;
    assign popped_length   = head.popped_length;
    assign last            = head.last;
    assign used_bytes      = head.used_bytes;
    assign dropped_records = head.dropped_records;

endmodule

[dv/length_prefixed_record_fifo_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for length_prefixed_record_fifo: directed and random record
// traffic, with each result item checked against a cycle-free model of the record ring.
// Depends on lprf_pkg and the length_prefixed_record_fifo RTL.
module length_prefixed_record_fifo_tb;
    import lprf_pkg::*;

    localparam int RING_DEPTH   = 1024;
    localparam int REC_MAX      = 63;
    localparam int HOLD_CYCLES  = 600;
    localparam int TAIL_CYCLES  = 32;
    localparam int REPORT_LIMIT = 10;

    typedef logic [USED_W-1:0] ring_ptr_t;

    // Ports of the block. Every input starts at a known value.
    logic              clk            = 1'b0;
    logic              rst_n          = 1'b0;
    logic              cfg_write_en   = 1'b0;
    logic              cfg_write_data = 1'b0;
    logic              push           = 1'b0;
    logic              full;
    logic [1:0]        operation      = OP_PUSH_HDR;
    logic [BYTE_W-1:0] data_byte      = '0;
    logic [LEN_W-1:0]  record_length  = '0;
    logic              empty;
    logic              pop            = 1'b0;
    logic [2:0]        status;
    logic [BYTE_W-1:0] out_byte;
    logic              byte_valid;
    logic [LEN_W-1:0]  popped_length;
    logic              last;
    logic [USED_W-1:0] used_bytes;
    logic [DROP_W-1:0] dropped_records;

    // Shadow copy of the record ring. The pointers are exactly ten bits wide, so
    // plain addition wraps round the 1024-entry ring just as the block does.
    bit [BYTE_W-1:0] ring_copy [RING_DEPTH];
    ring_ptr_t       rd_ptr;
    ring_ptr_t       cm_ptr;
    ring_ptr_t       wr_ptr;
    int              bytes_left;
    bit              rec_open;
    bit              replace_on;

    res_t            due_results [$];
    cmd_t            cmd_backlog [$];
    int              items_queued;
    int              mismatches;
    int              sender_idle_pct;
    int              rx_stall_pct;
    bit              hold_request = 1'b0;
    bit              rx_hold      = 1'b0;

    length_prefixed_record_fifo i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write_en    (cfg_write_en),
        .cfg_write_data  (cfg_write_data),
        .push            (push),
        .full            (full),
        .operation       (operation),
        .data_byte       (data_byte),
        .record_length   (record_length),
        .empty           (empty),
        .pop             (pop),
        .status          (status),
        .out_byte        (out_byte),
        .byte_valid      (byte_valid),
        .popped_length   (popped_length),
        .last            (last),
        .used_bytes      (used_bytes),
        .dropped_records (dropped_records)
    );

    initial
    begin : clock_gen
        forever #2 clk = ~clk;
    end

    // Hard stop in case the block locks up or stops producing results.
    initial
    begin : watchdog
        #2000000;
        $display("length_prefixed_record_fifo_tb: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Model of the record ring
    // ------------------------------------------------------------------

    // Committed bytes, headers included.
    function automatic int held_bytes();
        ring_ptr_t diff;
        diff = cm_ptr - rd_ptr;
        return diff;
    endfunction

    // One slot is always left empty, hence the minus one.
    function automatic int room_bytes();
        return RING_DEPTH - 1 - held_bytes();
    endfunction

    function automatic void wipe_ring();
        rd_ptr     = '0;
        cm_ptr     = '0;
        wr_ptr     = '0;
        bytes_left = 0;
        rec_open   = 1'b0;
    endfunction

    // Length held in the header at the read pointer. A header that claims more
    // than a record may hold, or more than is committed, wipes the whole queue
    // and yields -1.
    function automatic int stored_header_len();
        ring_ptr_t hi_pos;
        int        hl;
        hi_pos = rd_ptr + 1'b1;
        hl     = {ring_copy[hi_pos], ring_copy[rd_ptr]};
        if (hl > REC_MAX || held_bytes() < hl + HDR_BYTES)
        begin
            wipe_ring();
            return -1;
        end
        return hl;
    endfunction

    // The used count is taken from the ring as it stands when the result is made.
    function automatic void queue_result(status_t st, logic [BYTE_W-1:0] b, logic bv,
                                         int plen, logic lst, int dropped);
        res_t r;
        r.status          = st;
        r.out_byte        = b;
        r.byte_valid      = bv;
        r.popped_length   = LEN_W'(plen);
        r.last            = lst;
        r.used_bytes      = USED_W'(held_bytes());
        r.dropped_records = DROP_W'(dropped);
        due_results.push_back(r);
    endfunction

    // Works out every result item that one accepted input item must produce.
    // A record length above the maximum cannot be expressed in six bits, so
    // that rejection never arises here.
    function automatic void predict_record_results(op_t op, logic [BYTE_W-1:0] dbyte,
                                                   logic [LEN_W-1:0] len_field);
        int        n;
        int        hl;
        int        dropped;
        ring_ptr_t rp;
        n       = len_field;
        dropped = 0;
        case (op)
            OP_PUSH_HDR:
            begin
                // A new header abandons any record still being written.
                if (rec_open)
                begin
                    wr_ptr     = cm_ptr;
                    rec_open   = 1'b0;
                    bytes_left = 0;
                end
                if (replace_on)
                begin
                    while (room_bytes() <= n + HDR_BYTES && rd_ptr != cm_ptr)
                    begin
                        hl = stored_header_len();
                        if (hl >= 0)
                        begin
                            rd_ptr = ring_ptr_t'(rd_ptr + HDR_BYTES + hl);
                            dropped++;
                        end
                    end
                end
                if (room_bytes() <= n + HDR_BYTES)
                begin
                    queue_result(ST_FULL, '0, 1'b0, 0, 1'b1, dropped);
                end
                else
                begin
                    wr_ptr            = cm_ptr;
                    ring_copy[wr_ptr] = BYTE_W'(n);
                    wr_ptr            = wr_ptr + 1'b1;
                    ring_copy[wr_ptr] = '0;
                    wr_ptr            = wr_ptr + 1'b1;
                    // An empty record is committed at once.
                    if (n == 0)
                    begin
                        cm_ptr = wr_ptr;
                    end
                    else
                    begin
                        rec_open   = 1'b1;
                        bytes_left = n;
                    end
                    queue_result(ST_OK, '0, 1'b0, 0, 1'b1, dropped);
                end
            end
            OP_PUSH_DATA:
            begin
                if (!rec_open)
                begin
                    queue_result(ST_STRAY, '0, 1'b0, 0, 1'b1, 0);
                end
                else
                begin
                    ring_copy[wr_ptr] = dbyte;
                    wr_ptr            = wr_ptr + 1'b1;
                    bytes_left--;
                    if (bytes_left == 0)
                    begin
                        cm_ptr   = wr_ptr;
                        rec_open = 1'b0;
                    end
                    queue_result(ST_OK, '0, 1'b0, 0, 1'b1, 0);
                end
            end
            OP_POP:
            begin
                if (rd_ptr == cm_ptr)
                begin
                    queue_result(ST_EMPTY, '0, 1'b0, 0, 1'b1, 0);
                end
                else
                begin
                    hl = stored_header_len();
                    if (hl < 0)
                    begin
                        queue_result(ST_CORRUPT, '0, 1'b0, 0, 1'b1, 0);
                    end
                    else
                    begin
                        rp     = ring_ptr_t'(rd_ptr + HDR_BYTES);
                        rd_ptr = ring_ptr_t'(rd_ptr + HDR_BYTES + hl);
                        if (hl == 0)
                        begin
                            queue_result(ST_OK, '0, 1'b0, 0, 1'b1, 0);
                        end
                        else
                        begin
                            for (int i = 0; i < hl; i++)
                            begin
                                queue_result(ST_OK, ring_copy[rp], 1'b1, hl, i == hl - 1, 0);
                                rp = rp + 1'b1;
                            end
                        end
                    end
                end
            end
            default:
            begin
                wipe_ring();
                queue_result(ST_OK, '0, 1'b0, 0, 1'b1, 0);
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Sender: presents the oldest pending item and models it once taken
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : sender_drive
        cmd_t next_cmd;
        if (!rst_n)
        begin
            push <= 1'b0;
        end
        else
        begin
            if (push && !full)
                predict_record_results(op_t'(operation), data_byte, record_length);
            // The ports may only change once the current item has gone in.
            if (!push || !full)
            begin
                if (cmd_backlog.size() != 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    next_cmd      = cmd_backlog.pop_front();
                    push          <= 1'b1;
                    operation     <= next_cmd.op;
                    data_byte     <= next_cmd.data_byte;
                    record_length <= next_cmd.record_length;
                end
                else
                begin
                    push <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: takes result items and compares them with the oldest one due
    // ------------------------------------------------------------------
    function automatic bit count_mismatch();
        mismatches++;
        return mismatches <= REPORT_LIMIT;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : result_check
        res_t want;
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (due_results.size() == 0)
                begin
                    if (count_mismatch())
                        $display("%0t: result item with none due: status %0d byte %02h",
                                 $time, status, out_byte);
                end
                else
                begin
                    want = due_results.pop_front();
                    if (status !== want.status || out_byte !== want.out_byte
                        || byte_valid !== want.byte_valid
                        || popped_length !== want.popped_length || last !== want.last
                        || used_bytes !== want.used_bytes
                        || dropped_records !== want.dropped_records)
                    begin
                        if (count_mismatch())
                        begin
                            $display("%0t: expected st %0d byte %02h bv %0b len %0d last %0b",
                                     $time, want.status, want.out_byte, want.byte_valid,
                                     want.popped_length, want.last);
                            $display("    used %0d drop %0d", want.used_bytes,
                                     want.dropped_records);
                            $display("    got st %0d byte %02h bv %0b len %0d last %0b",
                                     status, out_byte, byte_valid, popped_length, last);
                            $display("    used %0d drop %0d", used_bytes, dropped_records);
                        end
                    end
                end
            end
            pop <= !rx_hold && $urandom_range(99) >= rx_stall_pct;
        end
    end

    // Long receiver hold-off: with the sender still offering items, the result
    // queue and then the command queue fill, so full must rise and hold.
    initial
    begin : rx_hold_off
        wait (hold_request);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    function automatic void add_item(op_t op, int dbyte, int len);
        cmd_t c;
        c.op            = op;
        c.data_byte     = BYTE_W'(dbyte);
        c.record_length = LEN_W'(len);
        cmd_backlog.push_back(c);
        items_queued++;
    endfunction

    // A header followed by the given number of data bytes; fewer bytes than the
    // header claims leave the record open.
    function automatic void add_record(int len, int sent);
        add_item(OP_PUSH_HDR, $urandom_range(255), len);
        repeat (sent) add_item(OP_PUSH_DATA, $urandom_range(255), $urandom_range(63));
    endfunction

    // Mostly short records, with the occasional long one and the maximum.
    function automatic int pick_len();
        int r;
        r = $urandom_range(99);
        if (r < 65)
            return $urandom_range(8);
        if (r < 90)
            return $urandom_range(REC_MAX - 1, 9);
        return REC_MAX;
    endfunction

    // Well-formed records make up most of the traffic; the rest is cut-short
    // records, pops, clears, stray bytes and wholly random items.
    function automatic void add_random_traffic(int n);
        int target;
        int r;
        int len;
        target = items_queued + n;
        while (items_queued < target)
        begin
            r = $urandom_range(99);
            if (r < 55)
            begin
                len = pick_len();
                add_record(len, len);
            end
            else if (r < 65)
            begin
                len = pick_len();
                add_record(len, (len == 0) ? 0 : $urandom_range(len - 1));
            end
            else if (r < 85)
                add_item(OP_POP, $urandom_range(255), $urandom_range(63));
            else if (r < 89)
                add_item(OP_CLEAR, $urandom_range(255), $urandom_range(63));
            else if (r < 94)
                add_item(OP_PUSH_DATA, $urandom_range(255), $urandom_range(63));
            else
                add_item(op_t'($urandom_range(3)), $urandom_range(255), $urandom_range(63));
        end
    endfunction

    // Waits until every pending item has gone in and every result has come out.
    task automatic drain();
        do
            @(negedge clk);
        while (cmd_backlog.size() != 0 || push || due_results.size() != 0);
    endtask

    // The register is only written once the block has gone quiet: after the drain
    // and a further pause.
    task automatic start_phase(bit mode, int idle_pct, int stall_pct);
        drain();
        repeat (16) @(posedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= mode;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        replace_on   = mode;
        @(negedge clk);
        sender_idle_pct = idle_pct;
        rx_stall_pct    = stall_pct;
    endtask

    initial
    begin : stimulus
        int len;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, reject mode, no idling on either side.
        start_phase(1'b0, 0, 0);
        add_item(OP_POP, 8'hFF, 0);             // pop with nothing committed
        add_item(OP_PUSH_DATA, 8'hFF, REC_MAX); // byte with no open record
        add_item(OP_PUSH_HDR, 8'hFF, 0);        // empty record, committed at once
        add_item(OP_POP, 8'h00, REC_MAX);       // pop of the empty record
        add_item(OP_PUSH_HDR, 8'h00, 3);
        add_item(OP_PUSH_DATA, 8'h00, 0);
        add_item(OP_PUSH_DATA, 8'hFF, REC_MAX);
        add_item(OP_PUSH_DATA, 8'h5A, 21);
        add_item(OP_POP, 8'hA5, 42);
        add_item(OP_PUSH_HDR, 8'h00, REC_MAX);  // longest record, left unfinished
        add_item(OP_PUSH_DATA, 8'h11, 0);
        add_item(OP_PUSH_HDR, 8'h3C, 2);        // abandons the open record
        add_item(OP_PUSH_DATA, 8'hAA, 1);
        add_item(OP_PUSH_DATA, 8'h55, 2);
        add_item(OP_PUSH_HDR, 8'hC3, 4);
        add_item(OP_PUSH_DATA, 8'h01, 5);
        add_item(OP_CLEAR, 8'hFE, 6);           // clear with a record still open
        add_item(OP_POP, 8'h00, 0);
        add_item(OP_PUSH_HDR, 8'h00, 1);
        add_item(OP_PUSH_DATA, 8'h7F, 63);
        add_item(OP_POP, 8'h80, 0);
        add_item(OP_CLEAR, 8'h00, 0);           // clear of an empty queue

        // Random mix with a bursty sender.
        start_phase(1'b0, 49, 0);
        add_random_traffic(50);

        // Long records while the receiver holds off for a long stretch.
        start_phase(1'b0, 0, 0);
        hold_request = 1'b1;
        repeat (2)
        begin
            len = $urandom_range(REC_MAX, 40);
            add_record(len, len);
        end
        add_item(OP_POP, $urandom_range(255), $urandom_range(63));

        // Replace mode with a receiver that stalls often.
        start_phase(1'b1, 0, 49);
        add_random_traffic(30);

        start_phase(1'b1, 10, 10);
        add_random_traffic(30);

        start_phase(1'b0, 0, 0);
        add_random_traffic(25);

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (due_results.size() != 0)
        begin
            $display("%0d result items never arrived", due_results.size());
            mismatches += due_results.size();
        end
        if (mismatches == 0)
            $display("length_prefixed_record_fifo_tb: PASS");
        else
            $display("length_prefixed_record_fifo_tb: FAIL");
        $finish;
    end

endmodule
